FILE: sv/u2u8_pkg.sv
// u2u8_pkg: types, constants and the code point encoder shared by the
// UTF-16 to UTF-8 encoder. No dependencies.
package u2u8_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] QMARK     = 8'h3F;
	localparam logic [5:0] TAG_HIGH  = 6'b110110;
	localparam logic [5:0] TAG_LOW   = 6'b110111;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// Up to four bytes, first byte in bits [7:0]
	typedef struct packed {
		logic [31:0] bytes;
		logic [1:0]  len_m1;
		logic        eos;
	} job_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  n;
	} enc_t;

	function automatic enc_t encode_point(input logic [20:0] cp);
		enc_t r;
		r.bytes = '0;
		r.n     = 3'd1;
		if (cp < 21'h80) begin
			r.bytes = {24'h0, 1'b0, cp[6:0]};
			r.n     = 3'd1;
		end else if (cp < 21'h800) begin
			r.bytes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			r.n     = 3'd2;
		end else if (cp < 21'h10000) begin
			r.bytes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			r.n     = 3'd3;
		end else begin
			r.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
				5'b11110, cp[20:18]};
			r.n     = 3'd4;
		end
		return r;
	endfunction

endpackage

FILE: sv/u2u8_if.sv
// u2u8_unit_if and u2u8_byte_if: valid/ready channels of the encoder.
// No dependencies.
interface u2u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_string;

	modport source (output valid, output code_unit, output end_of_string, input ready);
	modport sink (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u2u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_item;
	logic       last_of_string;

	modport source (output valid, output out_byte, output last_of_item,
		output last_of_string, input ready);
	modport sink (input valid, input out_byte, input last_of_item,
		input last_of_string, output ready);
endinterface

FILE: sv/u2u8_front.sv
// u2u8_front: accepts code units, tracks the pending high surrogate and
// builds byte jobs. Depends on u2u8_pkg and u2u8_unit_if.
module u2u8_front
	import u2u8_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	u2u8_unit_if.sink     code_units,
	input  logic          q_full,
	output logic          push,
	output job_t          push_job
);

	logic       pend_q;
	logic [9:0] hb_q;
	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       pair;
	logic       eos;
	logic       keep;
	enc_t       enc;
	enc_t       base;
	enc_t       total;

	assign code_units.ready = !q_full;
	assign accept  = code_units.valid && code_units.ready;
	assign eos     = code_units.end_of_string;
	assign is_high = code_units.code_unit[15:10] == TAG_HIGH;
	assign is_low  = code_units.code_unit[15:10] == TAG_LOW;
	assign pair    = pend_q && is_low;
	assign keep    = !pair && is_high && !eos;

	always_comb begin
		if (pair)
			enc = encode_point(SUPP_BASE + {1'b0, hb_q, code_units.code_unit[9:0]});
		else
			enc = encode_point({5'd0, code_units.code_unit});

		if (pair) begin
			base = enc;
		end else if (is_low) begin
			base.bytes = {24'h0, QMARK};
			base.n     = 3'd1;
		end else if (is_high && !eos) begin
			base.bytes = '0;
			base.n     = 3'd0;
		end else begin
			base = enc;
		end

		// orphaned high surrogate: '?' ahead of whatever this unit gives
		if (pend_q && !pair) begin
			total.bytes = {base.bytes[23:0], QMARK};
			total.n     = base.n + 3'd1;
		end else begin
			total = base;
		end

		push_job.bytes  = total.bytes;
		push_job.len_m1 = 2'(total.n - 3'd1);
		push_job.eos    = eos;
	end

	assign push = accept && (total.n != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			hb_q   <= '0;
		end else if (accept) begin
			pend_q <= keep;
			hb_q   <= code_units.code_unit[9:0];
		end
	end

endmodule

FILE: sv/u2u8_queue.sv
// u2u8_queue: short FIFO of byte jobs between front and back.
// Depends on u2u8_pkg.
module u2u8_queue
	import u2u8_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t pop_job
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign avail   = cnt_q != '0;
	assign pop_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/u2u8_back.sv
// u2u8_back: takes jobs from the queue and sends their bytes one per cycle,
// while the output is not stalled, through an output register. Depends on u2u8_pkg and u2u8_byte_if.
module u2u8_back
	import u2u8_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_avail,
	input  job_t          q_job,
	output logic          q_pop,
	u2u8_byte_if.source   utf8_bytes
);

	logic        busy_q;
	logic [31:0] bytes_q;
	logic [1:0]  rem_q;
	logic        eos_q;
	logic        ov_q;
	logic [7:0]  ob_q;
	logic        oli_q;
	logic        ols_q;
	logic        adv;
	logic        done;

	assign adv   = !ov_q || utf8_bytes.ready;
	assign done  = busy_q && adv && (rem_q == 2'd0);
	assign q_pop = q_avail && (!busy_q || done);

	assign utf8_bytes.valid          = ov_q;
	assign utf8_bytes.out_byte       = ob_q;
	assign utf8_bytes.last_of_item   = oli_q;
	assign utf8_bytes.last_of_string = ols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (adv)
				ov_q <= busy_q;
			if (q_pop)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			ob_q  <= bytes_q[7:0];
			oli_q <= rem_q == 2'd0;
			ols_q <= (rem_q == 2'd0) && eos_q;
		end
		if (q_pop) begin
			bytes_q <= q_job.bytes;
			rem_q   <= q_job.len_m1;
			eos_q   <= q_job.eos;
		end else if (adv && busy_q) begin
			bytes_q <= {8'h0, bytes_q[31:8]};
			rem_q   <= rem_q - 2'd1;
		end
	end

endmodule

FILE: sv/utf16_to_utf8_encoder_unit.sv
// utf16_to_utf8_encoder_unit: top level of the UTF-16 to UTF-8 encoder.
// Depends on u2u8_pkg, u2u8_if, u2u8_front, u2u8_queue, u2u8_back.
//
//   channel      role   payload
//   code_units   sink   code_unit[15:0], end_of_string
//   utf8_bytes   source out_byte[7:0], last_of_item, last_of_string
//
// One output byte per cycle while the output is not stalled: a unit gives
// one to four bytes, sent in turn by the back end's serialiser (a held high
// surrogate gives none). Units are taken every cycle while the
// job queue has room. Reset clears the pending surrogate, queue and output
// register. A stalled output fills the queue, then drops code_units.ready.
module utf16_to_utf8_encoder_unit
	import u2u8_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	u2u8_unit_if.sink     code_units,
	u2u8_byte_if.source   utf8_bytes
);

	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	logic q_avail;
	job_t q_job;

	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_units (code_units),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.pop_job  (q_job)
	);

	u2u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_job      (q_job),
		.q_pop      (q_pop),
		.utf8_bytes (utf8_bytes)
	);

endmodule
